@@ sv/tpq_pkg.sv @@
`default_nettype none
package tpq_pkg;

  localparam int RATE_W      = 21;
  localparam int COUNT_W     = 9;
  localparam int LIMIT_W     = 10;
  localparam int LEVEL_W     = 17;
  localparam int FROM_W      = 9;
  localparam int CDF_W       = 17;
  localparam int QK_W        = 8;
  localparam int MEAN_W      = 24;
  localparam int IN_DATA_W   = 40;
  localparam int OUT_DATA_W  = 56;
  localparam int CFG_ADDR_W  = 1;

  localparam int W_W         = 54;
  localparam int RATE_SHIFT  = 16;
  localparam int MUL_SPLIT   = 27;
  localparam int MEAN_FRAC   = 16;
  localparam int PROD_W      = W_W + RATE_W - RATE_SHIFT;

  localparam logic [W_W-1:0] WEIGHT_ONE = W_W'(64'h1_0000_0000);
  localparam logic [W_W-1:0] WEIGHT_CAP = W_W'(64'h20_0000_0000_0000);

  localparam logic [RATE_W-1:0]  RATE_RESET  = RATE_W'(65536);
  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(10);

  localparam logic [CFG_ADDR_W-1:0] CFG_RATE  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_COUNT = 1'b1;

  typedef enum logic [1:0] {
    DIV_WEIGHT,
    DIV_FRAC,
    DIV_MEAN
  } div_sel_t;

  typedef struct packed {
    logic     w_init;
    logic     mul_lo;
    logic     mul_hi;
    logic     div_start;
    div_sel_t div_sel;
    logic     w_store;
    logic     k_clear;
    logic     n_read;
    logic     n_store;
    logic     q_step;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic k_end;
    logic div_busy;
    logic out_full;
  } sts_t;

endpackage
`default_nettype wire

@@ sv/tpq_div.sv @@
`default_nettype none
module tpq_div #(
  parameter int RW = 62,
  parameter int BW = 70,
  parameter int SW = $clog2(BW + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [RW-1:0] rem_init,
  input  wire logic [BW-1:0] bits,
  input  wire logic [RW-1:0] divisor,
  input  wire logic [SW-1:0] steps,
  output logic               busy,
  output logic [BW-1:0]      quot
);

  logic [RW-1:0] rem;
  logic [BW-1:0] src;
  logic [RW-1:0] dvs;
  logic [SW-1:0] left;
  logic [RW:0]   shifted;
  logic          ge;

  assign shifted = {rem, src[BW-1]};
  assign ge      = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      left <= '0;
    end else if (start) begin
      busy <= (steps != '0);
      left <= steps;
    end else if (busy) begin
      left <= left - SW'(1);
      busy <= (left != SW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= rem_init;
      src  <= bits;
      dvs  <= divisor;
      quot <= '0;
    end else if (busy) begin
      rem  <= ge ? RW'(shifted - {1'b0, dvs}) : shifted[RW-1:0];
      src  <= src << 1;
      quot <= {quot[BW-2:0], ge};
    end
  end

endmodule
`default_nettype wire

@@ sv/tpq_ctrl.sv @@
`default_nettype none
module tpq_ctrl (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire tpq_pkg::sts_t sts,
  output tpq_pkg::cmd_t     cmd
);

  typedef enum logic [3:0] {
    IDLE, W_INIT, W_CHECK, W_MUL1, W_DIVGO, W_DIV,
    N_READ, N_DIVGO, N_DIV, Q_RUN, M_GO, M_DIV
  } state_t;

  state_t state, state_next;
  logic   table_ready;

  assign in_ready = (state == IDLE);

  always_comb begin
    cmd        = '0;
    cmd.div_sel = tpq_pkg::DIV_WEIGHT;
    state_next = state;
    unique case (state)
      IDLE: begin
        if (in_valid) state_next = table_ready ? Q_RUN : W_INIT;
      end
      W_INIT: begin
        cmd.w_init = 1'b1;
        state_next = W_CHECK;
      end
      W_CHECK: begin
        if (sts.k_end) begin
          cmd.k_clear = 1'b1;
          state_next  = N_READ;
        end else begin
          cmd.mul_lo = 1'b1;
          state_next = W_MUL1;
        end
      end
      W_MUL1: begin
        cmd.mul_hi = 1'b1;
        state_next = W_DIVGO;
      end
      W_DIVGO: begin
        cmd.div_start = 1'b1;
        state_next    = W_DIV;
      end
      W_DIV: begin
        if (!sts.div_busy) begin
          cmd.w_store = 1'b1;
          state_next  = W_CHECK;
        end
      end
      N_READ: begin
        if (sts.k_end) begin
          cmd.k_clear = 1'b1;
          state_next  = Q_RUN;
        end else begin
          cmd.n_read = 1'b1;
          state_next = N_DIVGO;
        end
      end
      N_DIVGO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = tpq_pkg::DIV_FRAC;
        state_next    = N_DIV;
      end
      N_DIV: begin
        if (!sts.div_busy) begin
          cmd.n_store = 1'b1;
          state_next  = N_READ;
        end
      end
      Q_RUN: begin
        if (sts.k_end) state_next = M_GO;
        else cmd.q_step = 1'b1;
      end
      M_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = tpq_pkg::DIV_MEAN;
        state_next    = M_DIV;
      end
      M_DIV: begin
        if (!sts.div_busy && !sts.out_full) begin
          cmd.out_load = 1'b1;
          state_next   = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= IDLE;
      table_ready <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) table_ready <= 1'b0;
      else if (state == N_READ && sts.k_end) table_ready <= 1'b1;
    end
  end

endmodule
`default_nettype wire

@@ sv/tpq_datapath.sv @@
`default_nettype none
module tpq_datapath #(
  parameter int MAX_CATEGORIES = 256,
  parameter int PROB_FRAC_BITS = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [tpq_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  wire logic [tpq_pkg::RATE_W-1:0]       cfg_wdata,
  input  wire logic                             in_load,
  input  wire logic [tpq_pkg::IN_DATA_W-1:0]    in_data,
  input  wire tpq_pkg::cmd_t                    cmd,
  output tpq_pkg::sts_t                         sts,
  input  wire logic                             out_ready,
  output logic                                  out_valid,
  output logic [tpq_pkg::OUT_DATA_W-1:0]        out_data
);

  localparam int N       = MAX_CATEGORIES;
  localparam int F       = PROB_FRAC_BITS;
  localparam int KW      = $clog2(N);
  localparam int NW      = (KW + 1 > tpq_pkg::COUNT_W) ? KW + 1 : tpq_pkg::COUNT_W;
  localparam int SUM_W   = tpq_pkg::W_W + KW;
  localparam int P_W     = F + 1;
  localparam int LSH     = (F >= 16) ? F - 16 : 0;
  localparam int RSH     = (F < 16) ? 16 - F : 0;
  localparam int RUN_W   = tpq_pkg::LEVEL_W + LSH;
  localparam int CDFO_W  = RUN_W + RSH;
  localparam int NUM_W   = KW + F + 1;
  localparam int DEN_W   = F + 1;
  localparam int LW      = (KW + 2 > tpq_pkg::LIMIT_W) ? KW + 2 : tpq_pkg::LIMIT_W;
  localparam int FRAC_L  = tpq_pkg::W_W + F;
  localparam int MEAN_L  = KW + tpq_pkg::MEAN_FRAC;
  localparam int BW0     = (tpq_pkg::PROD_W > FRAC_L) ? tpq_pkg::PROD_W : FRAC_L;
  localparam int BW      = (BW0 > MEAN_L) ? BW0 : MEAN_L;
  localparam int SW      = $clog2(BW + 1);
  localparam int PP_W    = tpq_pkg::MUL_SPLIT + tpq_pkg::RATE_W;
  localparam int FULL_W  = tpq_pkg::W_W + tpq_pkg::RATE_W;

  logic [tpq_pkg::RATE_W-1:0]  rate;
  logic [tpq_pkg::COUNT_W-1:0] count;
  logic [NW-1:0]               cnt_ext;
  logic [NW-1:0]               n_clamp;
  logic [KW:0]                 n;
  logic [KW:0]                 k;

  logic [tpq_pkg::W_W-1:0] wmem [N];
  logic [P_W-1:0]          pmem [N];

  logic [tpq_pkg::W_W-1:0] w_prev;
  logic [SUM_W-1:0]        sum;
  logic [PP_W-1:0]         pp_lo;
  logic [PP_W-1:0]         pp_hi;
  logic [FULL_W-1:0]       full;
  logic [tpq_pkg::W_W-1:0] wrd;
  logic [tpq_pkg::W_W-1:0] w_sat;

  logic [tpq_pkg::LIMIT_W-1:0] cdf_limit;
  logic [tpq_pkg::LEVEL_W-1:0] prob_level;
  logic [tpq_pkg::FROM_W-1:0]  mean_from;
  logic [RUN_W-1:0]            level;

  logic              acc_valid;
  logic [KW-1:0]     k_acc;
  logic [P_W-1:0]    p_rd;
  logic [RUN_W-1:0]  cdf;
  logic [RUN_W-1:0]  run;
  logic [RUN_W-1:0]  run_next;
  logic              found;
  logic [KW-1:0]     qk;
  logic [NUM_W-1:0]  num;
  logic [DEN_W-1:0]  den;
  logic signed [LW-1:0] lim_s;
  logic signed [LW-1:0] k_s;

  logic              div_start;
  logic [SUM_W-1:0]  div_rem;
  logic [BW-1:0]     div_bits;
  logic [SUM_W-1:0]  div_dvs;
  logic [SW-1:0]     div_steps;
  logic              div_busy;
  logic [BW-1:0]     quot;

  logic [CDFO_W-1:0] cdf_o;
  logic [31:0]       qk_o;
  logic [tpq_pkg::CDF_W-1:0]  cdf_value;
  logic [tpq_pkg::QK_W-1:0]   quantile_k;
  logic [tpq_pkg::MEAN_W-1:0] cond_mean;

  assign cnt_ext = NW'(count);
  assign n_clamp = (cnt_ext == '0) ? NW'(1) : ((cnt_ext > NW'(N)) ? NW'(N) : cnt_ext);
  assign n       = n_clamp[KW:0];

  assign full  = ({pp_hi, {tpq_pkg::MUL_SPLIT{1'b0}}}) + FULL_W'(pp_lo);
  assign w_sat = (quot > BW'(tpq_pkg::WEIGHT_CAP)) ? tpq_pkg::WEIGHT_CAP
                                                   : quot[tpq_pkg::W_W-1:0];

  assign level    = (RUN_W'(prob_level) << LSH) >> RSH;
  assign run_next = run + RUN_W'(p_rd);
  assign lim_s    = LW'($signed(cdf_limit));
  assign k_s      = $signed(LW'(k_acc));

  assign div_start = cmd.div_start;
  always_comb begin
    div_rem   = '0;
    div_bits  = '0;
    div_dvs   = SUM_W'(k);
    div_steps = SW'(tpq_pkg::PROD_W);
    case (cmd.div_sel)
      tpq_pkg::DIV_FRAC: begin
        div_bits  = BW'({wrd, {F{1'b0}}}) << (BW - FRAC_L);
        div_dvs   = sum;
        div_steps = SW'(FRAC_L);
      end
      tpq_pkg::DIV_MEAN: begin
        div_rem   = SUM_W'(num >> KW);
        div_bits  = BW'({num[KW-1:0], {tpq_pkg::MEAN_FRAC{1'b0}}}) << (BW - MEAN_L);
        div_dvs   = SUM_W'(den);
        div_steps = SW'(MEAN_L);
      end
      default: begin
        div_bits = BW'(full[FULL_W-1:tpq_pkg::RATE_SHIFT]) << (BW - tpq_pkg::PROD_W);
      end
    endcase
  end

  tpq_div #(
    .RW (SUM_W),
    .BW (BW),
    .SW (SW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .rem_init (div_rem),
    .bits     (div_bits),
    .divisor  (div_dvs),
    .steps    (div_steps),
    .busy     (div_busy),
    .quot     (quot)
  );

  assign sts.k_end    = (k == n);
  assign sts.div_busy = div_busy;
  assign sts.out_full = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rate      <= tpq_pkg::RATE_RESET;
      count     <= tpq_pkg::COUNT_RESET;
      k         <= '0;
      acc_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_addr == tpq_pkg::CFG_RATE) rate <= cfg_wdata;
        else count <= cfg_wdata[tpq_pkg::COUNT_W-1:0];
      end
      if (in_load || cmd.k_clear) k <= '0;
      else if (cmd.w_init) k <= (KW+1)'(1);
      else if (cmd.w_store || cmd.n_store || cmd.q_step) k <= k + (KW+1)'(1);
      acc_valid <= cmd.q_step;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.w_init) wmem[0] <= tpq_pkg::WEIGHT_ONE;
    else if (cmd.w_store) wmem[k[KW-1:0]] <= w_sat;
    if (cmd.n_read) wrd <= wmem[k[KW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.n_store) pmem[k[KW-1:0]] <= quot[P_W-1:0];
    if (cmd.q_step) p_rd <= pmem[k[KW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.w_init) begin
      w_prev <= tpq_pkg::WEIGHT_ONE;
      sum    <= SUM_W'(tpq_pkg::WEIGHT_ONE);
    end else if (cmd.w_store) begin
      w_prev <= w_sat;
      sum    <= sum + SUM_W'(w_sat);
    end
    if (cmd.mul_lo) pp_lo <= PP_W'(w_prev[tpq_pkg::MUL_SPLIT-1:0]) * PP_W'(rate);
    if (cmd.mul_hi) pp_hi <= PP_W'(w_prev[tpq_pkg::W_W-1:tpq_pkg::MUL_SPLIT]) * PP_W'(rate);
    if (cmd.q_step) k_acc <= k[KW-1:0];
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      cdf_limit  <= in_data[9:0];
      prob_level <= in_data[26:10];
      mean_from  <= in_data[35:27];
      cdf        <= '0;
      run        <= '0;
      found      <= 1'b0;
      qk         <= KW'(n - (KW+1)'(1));
      num        <= '0;
      den        <= '0;
    end else if (acc_valid) begin
      if (k_s <= lim_s) cdf <= cdf + RUN_W'(p_rd);
      run <= run_next;
      if (!found && run_next >= level) begin
        qk    <= k_acc;
        found <= 1'b1;
      end
      if (32'(k_acc) >= 32'(mean_from)) begin
        num <= num + NUM_W'(k_acc) * NUM_W'(p_rd);
        den <= den + DEN_W'(p_rd);
      end
    end
  end

  assign cdf_o = (CDFO_W'(cdf) >> LSH) << RSH;
  assign qk_o  = 32'(qk);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      cdf_value  <= cdf_o[tpq_pkg::CDF_W-1:0];
      quantile_k <= qk_o[tpq_pkg::QK_W-1:0];
      cond_mean  <= (den == '0) ? '0 : quot[tpq_pkg::MEAN_W-1:0];
    end
  end

  assign out_data = {7'b0, cond_mean, quantile_k, cdf_value};

endmodule
`default_nettype wire

@@ sv/truncated_poisson_table_query_core.sv @@
// Truncated Poisson table query core.
// Configuration: cfg_we/cfg_addr/cfg_wdata write the rate (index 0, Q5.16) or the
// category count (index 1); write only while the block is idle. Any write
// invalidates the probability table.
// Input stream s_*: one query per transfer (cdf_limit, prob_level, mean_from).
// Output stream m_*: one result per query (cdf_value, quantile_k, cond_mean).
// The first query after reset or a configuration write rebuilds the table:
// each weight takes a check state, two multiply states, a divider start and
// a 59-step divider, and each normalized entry takes a 70-step divider. A query
// then reads the table, one entry per cycle for n categories, and then runs a
// 24-step divider for the mean. One query is worked on at a time.
// The result sits in an output register; the next query is accepted while it
// waits, and the core stalls before loading the next result until m_tready.
// Reset (rst, synchronous) restores rate 1.0 and count 10 and marks the table
// as not built.
`default_nettype none
module truncated_poisson_table_query_core #(
  parameter int MAX_CATEGORIES = 256,
  parameter int PROB_FRAC_BITS = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [tpq_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [tpq_pkg::RATE_W-1:0]     cfg_wdata,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // cdf_limit[9:0], prob_level[26:10], mean_from[35:27]
  input  wire logic [tpq_pkg::IN_DATA_W-1:0]  s_tdata,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // cdf_value[16:0], quantile_k[24:17], cond_mean[48:25]
  output logic [tpq_pkg::OUT_DATA_W-1:0]      m_tdata
);

  tpq_pkg::cmd_t cmd;
  tpq_pkg::sts_t sts;
  logic          in_load;

  assign in_load = s_tvalid && s_tready;

  tpq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tpq_datapath #(
    .MAX_CATEGORIES (MAX_CATEGORIES),
    .PROB_FRAC_BITS (PROB_FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_load   (in_load),
    .in_data   (s_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_data  (m_tdata)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_load |=> !s_tready)
    else $error("query accepted while another is in progress");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_tvalid || m_tready))
    else $error("result register overwritten");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !sts.div_busy)
    else $error("divider started while busy");

endmodule
`default_nettype wire

@@ test/tb_truncated_poisson_table_query_core.sv @@
`default_nettype none
module tb_truncated_poisson_table_query_core;

  localparam int NCAT = 256;
  localparam int WATCH_LIMIT = 250000;

  typedef struct {
    logic [tpq_pkg::CDF_W-1:0]  cdf;
    logic [tpq_pkg::QK_W-1:0]   qk;
    logic [tpq_pkg::MEAN_W-1:0] mean;
  } answer_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_we = 1'b0;
  logic [tpq_pkg::CFG_ADDR_W-1:0] cfg_addr = tpq_pkg::CFG_RATE;
  logic [tpq_pkg::RATE_W-1:0]     cfg_wdata = '0;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [tpq_pkg::IN_DATA_W-1:0]  s_tdata = '0;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [tpq_pkg::OUT_DATA_W-1:0] m_tdata;

  truncated_poisson_table_query_core dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // poisson table predictor state
  logic [tpq_pkg::RATE_W-1:0]  lambda_q16;
  logic [tpq_pkg::COUNT_W-1:0] cat_count;
  bit                          probs_valid;
  bit [63:0]                   poisson_probs [NCAT];

  answer_t expected_answers [$];
  int      errors;
  int      queries_sent;
  int      answers_checked;
  int      configs_done;
  int      idle_mode;
  int      watch_cnt;

  function automatic int active_cats();
    int n;
    n = cat_count;
    if (n == 0) n = 1;
    if (n > NCAT) n = NCAT;
    return n;
  endfunction

  function automatic void build_poisson_probs();
    bit [63:0] w [NCAT];
    bit [63:0] total, prod, q, r;
    int n;
    n = active_cats();
    w[0] = 64'd1 << 32;
    for (int k = 1; k < n; k++) begin
      prod = (w[k-1] >> 16) * 64'(lambda_q16)
           + (((w[k-1] & 64'hFFFF) * 64'(lambda_q16)) >> 16);
      prod = prod / 64'(k);
      if (prod > (64'd1 << 53)) prod = 64'd1 << 53;
      w[k] = prod;
    end
    total = 0;
    for (int k = 0; k < n; k++) total += w[k];
    for (int k = 0; k < n; k++) begin
      q = 0;
      r = w[k];
      if (r >= total) begin
        q = 1;
        r -= total;
      end
      for (int i = 0; i < 16; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= total) begin
          r -= total;
          q |= 1;
        end
      end
      poisson_probs[k] = q;
    end
    probs_valid = 1'b1;
  endfunction

  function automatic answer_t predict_answer(logic [tpq_pkg::LIMIT_W-1:0] lim_raw,
                                             logic [tpq_pkg::LEVEL_W-1:0] level,
                                             logic [tpq_pkg::FROM_W-1:0] from);
    answer_t a;
    int n, lim, qk;
    bit found;
    bit [63:0] cdf, run, num, den, mean;
    if (!probs_valid) build_poisson_probs();
    n = active_cats();
    lim = $signed(lim_raw);
    cdf = 0; run = 0; num = 0; den = 0; mean = 0;
    qk = n - 1;
    found = 1'b0;
    for (int k = 0; k < n; k++) begin
      if (k <= lim) cdf += poisson_probs[k];
      run += poisson_probs[k];
      if (!found && run >= 64'(level)) begin
        qk = k;
        found = 1'b1;
      end
      if (k >= int'(from)) begin
        num += 64'(k) * poisson_probs[k];
        den += poisson_probs[k];
      end
    end
    if (den != 0) mean = (num << 16) / den;
    a.cdf = cdf[tpq_pkg::CDF_W-1:0];
    a.qk = qk[tpq_pkg::QK_W-1:0];
    a.mean = mean[tpq_pkg::MEAN_W-1:0];
    return a;
  endfunction

  task automatic send_query(logic [tpq_pkg::LIMIT_W-1:0] lim,
                            logic [tpq_pkg::LEVEL_W-1:0] level,
                            logic [tpq_pkg::FROM_W-1:0] from);
    int pct;
    pct = (idle_mode == 1) ? 88 : (idle_mode == 3) ? 6 : 0;
    while ($urandom_range(99) < pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    expected_answers.push_back(predict_answer(lim, level, from));
    s_tvalid <= 1'b1;
    s_tdata <= {4'b0, from, level, lim};
    do @(posedge clk); while (!s_tready);
    queries_sent++;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_answers.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [tpq_pkg::CFG_ADDR_W-1:0] idx,
                           logic [tpq_pkg::RATE_W-1:0] val);
    wait_drained();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == tpq_pkg::CFG_RATE) lambda_q16 = val;
    else cat_count = val[tpq_pkg::COUNT_W-1:0];
    probs_valid = 1'b0;
    configs_done++;
  endtask

  task automatic test_directed();
    int n;
    n = active_cats();
    idle_mode = 0;
    send_query(-10'sd1, 17'd0, 9'd0);
    send_query(10'h200, 17'd65536, 9'd511);
    send_query(10'h1FF, 17'h1FFFF, 9'(n));
    send_query(10'd0, 17'd1, 9'(n - 1));
    send_query(10'(n - 1), 17'd32768, 9'd1);
    send_query(10'(n), 17'd65535, 9'd257);
    send_query(10'h3FE, 17'd65536, 9'd0);
    wait_drained();
    write_reg(tpq_pkg::CFG_RATE, 21'd0);
    send_query(10'd0, 17'd65536, 9'd0);
    send_query(10'd5, 17'd0, 9'd1);
    write_reg(tpq_pkg::CFG_COUNT, 21'h1FFE00);
    send_query(10'd0, 17'd65536, 9'd0);
    send_query(-10'sd1, 17'd1, 9'd1);
    write_reg(tpq_pkg::CFG_RATE, 21'h1FFFFF);
    write_reg(tpq_pkg::CFG_COUNT, 21'd300);
    send_query(10'd255, 17'd65536, 9'd200);
    send_query(10'd100, 17'd100, 9'd255);
    send_query(10'd300, 17'h1FFFF, 9'd256);
    write_reg(tpq_pkg::CFG_RATE, 21'd1);
    write_reg(tpq_pkg::CFG_COUNT, 21'd2);
    send_query(10'd0, 17'd65536, 9'd1);
    send_query(10'd1, 17'd65535, 9'd0);
    write_reg(tpq_pkg::CFG_RATE, 21'd1048576);
    write_reg(tpq_pkg::CFG_COUNT, 21'd256);
    send_query(10'd16, 17'd32768, 9'd16);
    send_query(10'd255, 17'd65536, 9'd255);
    wait_drained();
  endtask

  task automatic random_queries(int count);
    int n, sel;
    logic [tpq_pkg::LIMIT_W-1:0] lim;
    logic [tpq_pkg::LEVEL_W-1:0] level;
    logic [tpq_pkg::FROM_W-1:0]  from;
    n = active_cats();
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(9);
      lim = (sel < 7) ? tpq_pkg::LIMIT_W'($urandom_range(n + 1) - 1)
                      : tpq_pkg::LIMIT_W'($urandom);
      sel = $urandom_range(9);
      level = (sel < 7) ? tpq_pkg::LEVEL_W'($urandom_range(65536))
                        : tpq_pkg::LEVEL_W'($urandom);
      sel = $urandom_range(9);
      from = (sel < 7) ? tpq_pkg::FROM_W'($urandom_range(n + 1))
                       : tpq_pkg::FROM_W'($urandom);
      send_query(lim, level, from);
      if ($urandom_range(99) == 0) wait_drained();
    end
  endtask

  task automatic test_random();
    for (int ph = 0; ph < 16; ph++) begin
      if (ph == 5) begin
        write_reg(tpq_pkg::CFG_RATE, 21'($urandom_range(1048576, 1)));
        write_reg(tpq_pkg::CFG_COUNT, 21'd256);
      end else begin
        write_reg(tpq_pkg::CFG_RATE,
                  ($urandom_range(3) == 0) ? tpq_pkg::RATE_W'($urandom)
                                           : 21'($urandom_range(1048576, 1)));
        write_reg(tpq_pkg::CFG_COUNT, {12'($urandom), 9'($urandom_range(40))});
      end
      idle_mode = ph % 4;
      random_queries((ph == 5) ? 60 : 72);
    end
    wait_drained();
  endtask

  always @(posedge clk) begin
    if (idle_mode == 2) m_tready <= ($urandom_range(99) >= 88);
    else if (idle_mode == 3) m_tready <= ($urandom_range(99) >= 6);
    else m_tready <= 1'b1;
  end

  always @(posedge clk) begin
    answer_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_answers.size() == 0) begin
        $display("%0t: unexpected result %h", $time, m_tdata);
        errors++;
      end else begin
        want = expected_answers.pop_front();
        answers_checked++;
        if (m_tdata[16:0] !== want.cdf || m_tdata[24:17] !== want.qk
            || m_tdata[48:25] !== want.mean || m_tdata[55:49] !== '0) begin
          $display("%0t: expected cdf %0d qk %0d mean %0d, got cdf %0d qk %0d mean %0d",
                   $time, want.cdf, want.qk, want.mean,
                   m_tdata[16:0], m_tdata[24:17], m_tdata[48:25]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) watch_cnt <= 0;
    else watch_cnt <= watch_cnt + 1;
    if (watch_cnt >= WATCH_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, WATCH_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    errors = 0;
    queries_sent = 0;
    answers_checked = 0;
    configs_done = 0;
    idle_mode = 0;
    watch_cnt = 0;
    lambda_q16 = tpq_pkg::RATE_RESET;
    cat_count = tpq_pkg::COUNT_RESET;
    probs_valid = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random();
    wait_drained();
    repeat (300) @(posedge clk);
    $display("Covered %0d queries, %0d results checked, %0d register writes,",
             queries_sent, answers_checked, configs_done);
    $display("rates from zero to full scale and category counts from 0 to 300.");
    if (errors == 0 && expected_answers.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
`default_nettype wire
